FILE: sv/efct_pkg.sv
// Package for the expiring FIFO file cache table: types, constants and codes.
package efct_pkg;

  localparam int unsigned Entries = 64;
  localparam int unsigned IdxW = $clog2(Entries);
  localparam int unsigned CntW = $clog2(Entries + 1);

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] CfgEnable = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgExpiry = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgMaxSize = 2'd2;

  typedef enum logic [2:0] {
    StHit = 3'd0,
    StMiss = 3'd1,
    StStale = 3'd2,
    StExpired = 3'd3,
    StStored = 3'd4,
    StTooLarge = 3'd5,
    StDisabled = 3'd6
  } status_e;

  typedef enum logic {
    CmdLookup = 1'b0,
    CmdInsert = 1'b1
  } command_e;

  typedef struct packed {
    logic [0:0]  command;
    logic [63:0] file_key;
    logic [31:0] mod_time;
    logic [63:0] inode_number;
    logic [31:0] byte_size;
    logic [31:0] data_handle;
    logic [31:0] time_now;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] hit_handle;
    logic [31:0] hit_size;
    logic [0:0]  release_valid;
    logic [31:0] release_handle;
  } out_word_t;

  // One stored entry.
  typedef struct packed {
    logic [63:0] key;
    logic [31:0] mod_time;
    logic [63:0] inode;
    logic [31:0] size;
    logic [31:0] handle;
    logic [31:0] time_cached;
  } entry_t;

  typedef enum logic [2:0] {
    FsmIdle,
    FsmScan,
    FsmShift,
    FsmEvict,
    FsmAppend,
    FsmOut
  } fsm_e;

  // Memory access request from the controller.
  typedef struct packed {
    logic             rd_en;
    logic [IdxW-1:0]  rd_addr;
    logic             wr_en;
    logic [IdxW-1:0]  wr_addr;
    entry_t           wr_data;
  } mem_req_t;

endpackage

FILE: sv/expiring_fifo_file_cache_table_core.sv
// Top level of the expiring FIFO file cache table.
//   channel | direction | handshake
//   in      | input     | in_valid_i / in_stall_o, word in_word_i
//   out     | output    | out_valid_o / out_stall_i, word out_word_o
//   cfg     | input     | cfg_we_i, cfg_idx_i, cfg_data_i
// A lookup reads the entries one at a time and, on removal, shifts each later
// entry down one place; an insert evicts and shifts first when the table is full.
// The single read and write port of the entry memory sets this pace. Reset is
// asynchronous and empties the table at once. The result word holds until
// taken; the next word is accepted in the cycle after the result leaves.
module expiring_fifo_file_cache_table_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  efct_pkg::in_word_t                 in_word_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output efct_pkg::out_word_t                out_word_o,
  input  logic                               cfg_we_i,
  input  logic [efct_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [efct_pkg::CfgDataW-1:0]      cfg_data_i
);
  import efct_pkg::*;

  logic        enable_q;
  logic [31:0] expiry_q;
  logic [31:0] max_size_q;
  mem_req_t    mem_req;
  entry_t      mem_rd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b1;
      expiry_q <= 32'd60;
      max_size_q <= 32'd1048576;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgEnable: enable_q <= cfg_data_i[0];
        CfgExpiry: expiry_q <= cfg_data_i;
        CfgMaxSize: max_size_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  efct_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .in_word_i,
    .out_valid_o,
    .out_stall_i,
    .out_word_o,
    .cfg_enable_i(enable_q),
    .cfg_expiry_i(expiry_q),
    .cfg_max_size_i(max_size_q),
    .mem_req_o(mem_req),
    .mem_rd_i(mem_rd)
  );

  efct_ram u_ram (
    .clk_i,
    .req_i(mem_req),
    .rd_data_o(mem_rd)
  );

endmodule

FILE: sv/efct_ram.sv
// Single-port-write, single-port-read entry memory with a registered read.
module efct_ram (
  input  logic              clk_i,
  input  efct_pkg::mem_req_t req_i,
  output efct_pkg::entry_t  rd_data_o
);
  import efct_pkg::*;

  entry_t mem_q [Entries];

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_o <= mem_q[req_i.rd_addr];
    end
  end

endmodule

FILE: sv/efct_ctrl.sv
// Controller: scans, shifts and appends entries through the memory.
module efct_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  efct_pkg::in_word_t           in_word_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output efct_pkg::out_word_t          out_word_o,
  input  logic                         cfg_enable_i,
  input  logic [31:0]                  cfg_expiry_i,
  input  logic [31:0]                  cfg_max_size_i,
  output efct_pkg::mem_req_t           mem_req_o,
  input  efct_pkg::entry_t             mem_rd_i
);
  import efct_pkg::*;

  fsm_e            state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [IdxW-1:0] idx_q, idx_d;
  in_word_t        item_q, item_d;
  out_word_t       res_q, res_d;

  logic        take;
  logic        key_eq;
  logic        fresh_eq;
  logic [32:0] age;
  logic        expired;
  logic [CntW-1:0] idx_ext;

  assign take = in_valid_i && (state_q == FsmIdle);
  assign in_stall_o = (state_q != FsmIdle);
  assign out_valid_o = (state_q == FsmOut);
  assign out_word_o = res_q;
  assign idx_ext = CntW'(idx_q);

  assign key_eq = (mem_rd_i.key == item_q.file_key);
  assign fresh_eq = (mem_rd_i.mod_time == item_q.mod_time) &&
                    (mem_rd_i.inode == item_q.inode_number);
  // Signed 33-bit age; a negative age never expires.
  assign age = {1'b0, item_q.time_now} - {1'b0, mem_rd_i.time_cached};
  assign expired = !age[32] && (age[31:0] > cfg_expiry_i);

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    idx_d = idx_q;
    item_d = item_q;
    res_d = res_q;
    mem_req_o = '0;
    mem_req_o.wr_data = mem_rd_i;
    unique case (state_q)
      FsmIdle: begin
        if (take) begin
          item_d = in_word_i;
          res_d = '0;
          res_d.status = StMiss;
          idx_d = '0;
          if (!cfg_enable_i) begin
            res_d.status = StDisabled;
            state_d = FsmOut;
          end else if (in_word_i.command == CmdLookup) begin
            if (count_q == '0) begin
              state_d = FsmOut;
            end else begin
              mem_req_o.rd_en = 1'b1;
              state_d = FsmScan;
            end
          end else if (in_word_i.byte_size > cfg_max_size_i) begin
            res_d.status = StTooLarge;
            state_d = FsmOut;
          end else if (count_q == CntW'(Entries)) begin
            // Full: read entry 0 for its handle, then shift everything down.
            mem_req_o.rd_en = 1'b1;
            state_d = FsmEvict;
          end else begin
            state_d = FsmAppend;
          end
        end
      end
      FsmScan: begin
        if (key_eq) begin
          if (fresh_eq && !expired) begin
            res_d.status = StHit;
            res_d.hit_handle = mem_rd_i.handle;
            res_d.hit_size = mem_rd_i.size;
            state_d = FsmOut;
          end else begin
            res_d.status = fresh_eq ? StExpired : StStale;
            res_d.release_valid = 1'b1;
            res_d.release_handle = mem_rd_i.handle;
            if (idx_ext + 1'b1 < count_q) begin
              mem_req_o.rd_en = 1'b1;
              mem_req_o.rd_addr = idx_q + 1'b1;
              state_d = FsmShift;
            end else begin
              count_d = count_q - 1'b1;
              state_d = FsmOut;
            end
          end
        end else if (idx_ext + 1'b1 < count_q) begin
          idx_d = idx_q + 1'b1;
          mem_req_o.rd_en = 1'b1;
          mem_req_o.rd_addr = idx_q + 1'b1;
        end else begin
          state_d = FsmOut;
        end
      end
      FsmShift: begin
        // Entry idx+1 is on the read port: copy it to idx.
        mem_req_o.wr_en = 1'b1;
        mem_req_o.wr_addr = idx_q;
        idx_d = idx_q + 1'b1;
        if (idx_ext + 2'd2 < count_q) begin
          mem_req_o.rd_en = 1'b1;
          mem_req_o.rd_addr = idx_q + 2'd2;
        end else begin
          count_d = count_q - 1'b1;
          state_d = (item_q.command == CmdInsert) ? FsmAppend : FsmOut;
        end
      end
      FsmEvict: begin
        res_d.release_valid = 1'b1;
        res_d.release_handle = mem_rd_i.handle;
        mem_req_o.rd_en = 1'b1;
        mem_req_o.rd_addr = IdxW'(1);
        idx_d = '0;
        state_d = FsmShift;
      end
      FsmAppend: begin
        mem_req_o.wr_en = 1'b1;
        mem_req_o.wr_addr = count_q[IdxW-1:0];
        mem_req_o.wr_data.key = item_q.file_key;
        mem_req_o.wr_data.mod_time = item_q.mod_time;
        mem_req_o.wr_data.inode = item_q.inode_number;
        mem_req_o.wr_data.size = item_q.byte_size;
        mem_req_o.wr_data.handle = item_q.data_handle;
        mem_req_o.wr_data.time_cached = item_q.time_now;
        count_d = count_q + 1'b1;
        res_d.status = StStored;
        state_d = FsmOut;
      end
      FsmOut: begin
        if (!out_stall_i) begin
          state_d = FsmIdle;
        end
      end
      default: state_d = FsmIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FsmIdle;
      count_q <= '0;
      idx_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    res_q <= res_d;
  end

endmodule
